// File: src/cve_pkg.sv
package cve_pkg;

  localparam int SAMPLE_BITS_DEF  = 10;
  localparam int LINE_SAMPLES_DEF = 910;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BLANK_LEVEL     = 8'd0,
    REG_BURST_AMPLITUDE = 8'd1,
    REG_LUMA_GAIN       = 8'd2,
    REG_CHROMA_GAIN     = 8'd3,
    REG_ACTIVE_LINES    = 8'd4,
    REG_ACTIVE_WIDTH    = 8'd5,
    REG_BLANK_LINES     = 8'd6
  } cfg_reg_t;

  localparam logic [9:0] RST_BLANK_LEVEL     = 10'd255;
  localparam logic [8:0] RST_BURST_AMPLITUDE = 9'd114;
  localparam logic [9:0] RST_LUMA_GAIN       = 10'd768;
  localparam logic [9:0] RST_CHROMA_GAIN     = 10'd384;
  localparam logic [8:0] RST_ACTIVE_LINES    = 9'd220;
  localparam logic [9:0] RST_ACTIVE_WIDTH    = 10'd586;
  localparam logic [5:0] RST_BLANK_LINES     = 6'd33;

  localparam logic [9:0] VSYNC_LINES = 10'd9;
  localparam int         CALC_CYCLES = 8;

  // what level a sample carries
  typedef enum logic [1:0] {
    KIND_BLACK = 2'd0,
    KIND_SYNC  = 2'd1,
    KIND_BURST = 2'd2,
    KIND_PIXEL = 2'd3
  } kind_t;

  typedef struct packed {
    logic capture;
    logic load;
  } cve_cmd_t;

  function automatic logic signed [15:0] sin_rot(input logic [2:0] k);
    case (k)
      3'd0:    sin_rot = 16'sd8923;
      3'd1:    sin_rot = 16'sd15826;
      3'd2:    sin_rot = 16'sd857;
      3'd3:    sin_rot = -16'sd15296;
      3'd4:    sin_rot = -16'sd10311;
      default: sin_rot = 16'sd8923;
    endcase
  endfunction

  function automatic logic signed [15:0] cos_rot(input logic [2:0] k);
    case (k)
      3'd0:    cos_rot = 16'sd13741;
      3'd1:    cos_rot = -16'sd4240;
      3'd2:    cos_rot = -16'sd16362;
      3'd3:    cos_rot = -16'sd5872;
      3'd4:    cos_rot = 16'sd12733;
      default: cos_rot = 16'sd13741;
    endcase
  endfunction

  function automatic logic signed [15:0] sin_base(input logic [2:0] k);
    case (k)
      3'd0:    sin_base = 16'sd0;
      3'd1:    sin_base = 16'sd15582;
      3'd2:    sin_base = 16'sd9630;
      3'd3:    sin_base = -16'sd9630;
      3'd4:    sin_base = -16'sd15582;
      default: sin_base = 16'sd0;
    endcase
  endfunction

endpackage

// File: src/cve_ctrl.sv
module cve_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cve_pkg::cve_cmd_t cmd
);
  import cve_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam int CNT_BITS = $clog2(CALC_CYCLES);

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt;
  logic                out_free;

  assign in_ready    = (state == ST_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.load    = (state == ST_DONE) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.capture) state_next = ST_CALC;
      ST_CALC: if (cnt == CNT_BITS'(CALC_CYCLES - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CALC) cnt <= cnt + 1'b1;
      else cnt <= '0;
      if (cmd.load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: src/cve_datapath.sv
module cve_datapath #(
  parameter int SAMPLE_BITS  = cve_pkg::SAMPLE_BITS_DEF,
  parameter int LINE_SAMPLES = cve_pkg::LINE_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cve_pkg::cve_cmd_t                  cmd,
  input  logic                               cfg_valid,
  input  logic [cve_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cve_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  output logic [SAMPLE_BITS-1:0]             sample,
  output logic                               pixel_taken,
  output logic                               line_end,
  output logic                               field_end
);
  import cve_pkg::*;

  localparam int SEG_BACK  = LINE_SAMPLES * 2 / 100;
  localparam int SEG_SYNC  = LINE_SAMPLES * 75 / 1000;
  localparam int SEG_PRE   = LINE_SAMPLES * 6 / 1000;
  localparam int SEG_BURST = (LINE_SAMPLES * 44 / 1000) / 2 * 2;
  localparam int SEG_POST  = LINE_SAMPLES * 2 / 100;
  localparam int VSS       = LINE_SAMPLES * 4 / 100;
  localparam int VSL       = LINE_SAMPLES * 46 / 100;

  localparam logic [9:0] POS_SYNC  = 10'(SEG_BACK);
  localparam logic [9:0] POS_PRE   = 10'(SEG_BACK + SEG_SYNC);
  localparam logic [9:0] POS_BURST = 10'(SEG_BACK + SEG_SYNC + SEG_PRE);
  localparam logic [9:0] POS_POST  = 10'(SEG_BACK + SEG_SYNC + SEG_PRE + SEG_BURST);
  localparam logic [9:0] POS_PIC   = 10'(SEG_BACK + SEG_SYNC + SEG_PRE + SEG_BURST
                                         + SEG_POST);
  localparam logic [9:0] LAST_S    = 10'(LINE_SAMPLES - 1);
  localparam logic [9:0] VS_S      = 10'(VSS);
  localparam logic [9:0] VS_L      = 10'(VSL);
  localparam logic [9:0] VS_LS     = 10'(VSL + VSS);
  localparam logic [9:0] VS_LLS    = 10'(2 * VSL + VSS);
  localparam logic [9:0] VS_SSL    = 10'(2 * VSS + VSL);

  localparam logic signed [15:0] SAMPLE_MAX = 16'((1 << SAMPLE_BITS) - 1);

  // configuration
  logic [9:0] blank_level, luma_gain, chroma_gain, active_width;
  logic [8:0] burst_amplitude, active_lines;
  logic [5:0] blank_lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_level     <= RST_BLANK_LEVEL;
      burst_amplitude <= RST_BURST_AMPLITUDE;
      luma_gain       <= RST_LUMA_GAIN;
      chroma_gain     <= RST_CHROMA_GAIN;
      active_lines    <= RST_ACTIVE_LINES;
      active_width    <= RST_ACTIVE_WIDTH;
      blank_lines     <= RST_BLANK_LINES;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLANK_LEVEL:     blank_level     <= cfg_data[9:0];
        REG_BURST_AMPLITUDE: burst_amplitude <= cfg_data[8:0];
        REG_LUMA_GAIN:       luma_gain       <= cfg_data[9:0];
        REG_CHROMA_GAIN:     chroma_gain     <= cfg_data[9:0];
        REG_ACTIVE_LINES:    active_lines    <= cfg_data[8:0];
        REG_ACTIVE_WIDTH:    active_width    <= cfg_data[9:0];
        REG_BLANK_LINES:     blank_lines     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // raster timing
  logic [9:0] line_index, sample_index;
  logic       odd_line;
  logic [2:0] carrier_phase;

  logic [9:0] al, v, total, pic_off;
  logic [2:0] k, k_next;
  logic       in_vs, broad, vs_zero, lend, fend, is_pix;
  kind_t      kind_next;

  always_comb begin
    al      = {1'b0, active_lines};
    total   = al + VSYNC_LINES + {4'b0, blank_lines};
    v       = line_index - al;
    pic_off = sample_index - POS_PIC;
    k       = (carrier_phase > 3'd4) ? 3'd0 : carrier_phase;
    k_next  = (k == 3'd4) ? 3'd0 : k + 3'd1;
    in_vs   = (line_index >= al) && (line_index < al + VSYNC_LINES);
    broad   = (v >= 10'd3) && (v <= 10'd5);
    if (broad) begin
      vs_zero = (sample_index < VS_L) ||
                ((sample_index >= VS_LS) && (sample_index < VS_LLS));
    end else begin
      vs_zero = (sample_index < VS_S) ||
                ((sample_index >= VS_LS) && (sample_index < VS_SSL));
    end
    is_pix = (line_index < al) && (sample_index >= POS_PIC) && (pic_off < active_width);
    if (in_vs) kind_next = vs_zero ? KIND_SYNC : KIND_BLACK;
    else if (sample_index >= POS_SYNC && sample_index < POS_PRE) kind_next = KIND_SYNC;
    else if (sample_index >= POS_BURST && sample_index < POS_POST) kind_next = KIND_BURST;
    else if (is_pix) kind_next = KIND_PIXEL;
    else kind_next = KIND_BLACK;
    lend = (sample_index >= LAST_S);
    fend = lend && (line_index >= total - 10'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_index    <= '0;
      sample_index  <= '0;
      odd_line      <= 1'b0;
      carrier_phase <= '0;
    end else if (cmd.capture) begin
      if (fend) begin
        sample_index  <= '0;
        line_index    <= '0;
        odd_line      <= 1'b0;
        carrier_phase <= '0;
      end else if (lend) begin
        sample_index  <= '0;
        odd_line      <= !odd_line;
        line_index    <= line_index + 10'd1;
        carrier_phase <= k_next;
      end else begin
        sample_index  <= sample_index + 10'd1;
        carrier_phase <= k_next;
      end
    end
  end

  // captured item
  logic [7:0] r0, g0, b0;
  logic [2:0] k0;
  logic       odd0, lend0, fend0;
  kind_t      kind0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r0    <= red;
      g0    <= green;
      b0    <= blue;
      k0    <= k;
      odd0  <= odd_line;
      lend0 <= lend;
      fend0 <= fend;
      kind0 <= kind_next;
    end
  end

  // arithmetic stages, running freely off the captured item
  logic        [19:0] y1;
  logic signed [19:0] dr1, db1;
  logic signed [21:0] ci2, cq2;
  logic signed [25:0] bp2;
  logic signed [37:0] p3a, p3b;
  logic signed [31:0] yb3;
  logic [SAMPLE_BITS-1:0] bl3;
  logic signed [24:0] c4;
  logic signed [35:0] cm5;
  logic        [21:0] q6, q7;
  logic        [14:0] est7;
  logic [SAMPLE_BITS-1:0] px8;

  logic        [19:0] ysum;
  logic signed [31:0] iacc, qacc;
  logic signed [38:0] csum;
  logic signed [24:0] c_raw;
  logic signed [26:0] bsum;
  logic signed [11:0] dev;
  logic signed [15:0] blev;
  logic signed [36:0] num;
  logic signed [26:0] qt;
  logic        [36:0] eprod;
  logic        [22:0] rem;
  logic        [15:0] quot;

  always_comb begin
    ysum  = 20'(r0) * 20'd307 + 20'(g0) * 20'd604 + 20'(b0) * 20'd113;
    iacc  = 32'sd758 * 32'(dr1) - 32'sd276 * 32'(db1) + 32'sd512;
    qacc  = 32'sd492 * 32'(dr1) + 32'sd420 * 32'(db1) + 32'sd512;
    csum  = 39'(p3a) + 39'(p3b) + 39'sd8192;
    c_raw = 25'(csum >>> 14);
    bsum  = 27'(bp2) + 27'sd8192;
    dev   = 12'(bsum >>> 14);
    if (odd0) dev = -dev;
    blev  = $signed({6'b0, blank_level}) + 16'(dev);
    num   = 37'(yb3) + 37'(cm5);
    qt    = 27'(num >>> 10);
    eprod = 37'(q6) * 37'd16448;
    rem   = 23'(q7) - 23'(est7) * 23'd255;
    quot  = 16'(est7) + ((rem >= 23'd255) ? 16'd1 : 16'd0);
  end

  always_ff @(posedge clk) begin
    y1  <= ysum;
    dr1 <= $signed({2'b0, r0, 10'b0}) - $signed(ysum);
    db1 <= $signed({2'b0, b0, 10'b0}) - $signed(ysum);
    ci2 <= 22'(iacc >>> 10);
    cq2 <= 22'(qacc >>> 10);
    bp2 <= $signed({1'b0, burst_amplitude}) * sin_base(k0);
    p3a <= 38'(cq2) * 38'(sin_rot(k0));
    p3b <= 38'(ci2) * 38'(cos_rot(k0));
    yb3 <= $signed(32'(blank_level) * 32'd261120 + 32'(y1) * 32'(luma_gain)
                   + 32'd130560);
    if (blev < 16'sd0) bl3 <= '0;
    else if (blev > SAMPLE_MAX) bl3 <= SAMPLE_BITS'(SAMPLE_MAX);
    else bl3 <= SAMPLE_BITS'(blev);
    c4  <= odd0 ? c_raw : -c_raw;
    cm5 <= 36'(c4) * 36'($signed({1'b0, chroma_gain}));
    // negative numerator clamps to zero, huge ones saturate anyway
    if (num < 37'sd0) q6 <= '0;
    else if (qt > 27'sd4194303) q6 <= 22'h3FFFFF;
    else q6 <= 22'(qt);
    q7   <= q6;
    est7 <= eprod[36:22];
    if ($signed(quot) > SAMPLE_MAX) px8 <= SAMPLE_BITS'(SAMPLE_MAX);
    else px8 <= SAMPLE_BITS'(quot);
  end

  // output item register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_taken <= (kind0 == KIND_PIXEL);
      line_end    <= lend0;
      field_end   <= fend0;
      case (kind0)
        KIND_SYNC:  sample <= '0;
        KIND_BURST: sample <= bl3;
        KIND_PIXEL: sample <= px8;
        default:    sample <= SAMPLE_BITS'(blank_level);
      endcase
    end
  end

endmodule

// File: src/composite_video_encoder.sv
// composite video encoder: one composite sample item per accepted pixel item
// pixel path: the capture register, 8 arithmetic stages, then the output load;
// the load waits while the output register holds an item not yet taken
// one item at a time: the next item is taken once the result has moved to the
// output register
// reset (rst, synchronous): registers to defaults, raster at line 0 sample 0
module composite_video_encoder #(
  parameter int SAMPLE_BITS  = cve_pkg::SAMPLE_BITS_DEF,
  parameter int LINE_SAMPLES = cve_pkg::LINE_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cve_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cve_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // pixel items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  // sample items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [SAMPLE_BITS-1:0]             sample,
  output logic                               pixel_taken,
  output logic                               line_end,
  output logic                               field_end
);
  import cve_pkg::*;

  cve_cmd_t cmd;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // sequencer: idle, arithmetic count, hand-off to output
  cve_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // raster counters, segment decode, yiq and modulation math, output register
  cve_datapath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .LINE_SAMPLES (LINE_SAMPLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .sample      (sample),
    .pixel_taken (pixel_taken),
    .line_end    (line_end),
    .field_end   (field_end)
  );

endmodule

// File: src/cve_checker.sv
module cve_checker #(
  parameter int SAMPLE_BITS = cve_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample,
  input logic                   line_end,
  input logic                   field_end
);

  // a stalled sample item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample))
    else $error("output item changed while stalled");

  a_field_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !field_end || line_end)
    else $error("field end without line end");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind composite_video_encoder cve_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cve_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sample    (sample),
  .line_end  (line_end),
  .field_end (field_end)
);

// File: tb/tb_composite_video_encoder.sv
module tb_composite_video_encoder;
  import cve_pkg::*;

  // raster geometry, same integer rounding as the block
  localparam int LINE      = LINE_SAMPLES_DEF;
  localparam int SMAX      = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int SYNC_AT   = LINE * 2 / 100;
  localparam int PRE_AT    = SYNC_AT + LINE * 75 / 1000;
  localparam int BURST_AT  = PRE_AT + LINE * 6 / 1000;
  localparam int POST_AT   = BURST_AT + (LINE * 44 / 1000) / 2 * 2;
  localparam int PIC_AT    = POST_AT + LINE * 2 / 100;
  localparam int VS_SHORT  = LINE * 4 / 100;
  localparam int VS_LONG   = LINE * 46 / 100;
  localparam int VS_LINES  = 9;
  localparam longint DEN   = 261120;
  localparam int WD_LIMIT  = 5000;

  // expected sample item
  typedef struct {
    logic [9:0] smp;
    bit         taken;
    bit         lend;
    bit         fend;
  } sample_item_t;

  // raster tracker and expected sample store
  class raster_board;
    int unsigned black, amp, luma, chroma, act_lines, act_width, blank;
    int unsigned line_pos, sample_pos, phase;
    bit          odd;
    int          errors;
    int          fields_seen, pixels_seen;
    sample_item_t pending_q[$];
    int          rot_sin[5] = '{8923, 15826, 857, -15296, -10311};
    int          rot_cos[5] = '{13741, -4240, -16362, -5872, 12733};
    int          base_sin[5] = '{0, 15582, 9630, -9630, -15582};

    function new();
      black = RST_BLANK_LEVEL; amp = RST_BURST_AMPLITUDE; luma = RST_LUMA_GAIN;
      chroma = RST_CHROMA_GAIN; act_lines = RST_ACTIVE_LINES;
      act_width = RST_ACTIVE_WIDTH; blank = RST_BLANK_LINES;
      line_pos = 0; sample_pos = 0; phase = 0; odd = 0; errors = 0;
      fields_seen = 0; pixels_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, int unsigned val);
      case (idx)
        REG_BLANK_LEVEL:     black = val & 10'h3ff;
        REG_BURST_AMPLITUDE: amp = val & 9'h1ff;
        REG_LUMA_GAIN:       luma = val & 10'h3ff;
        REG_CHROMA_GAIN:     chroma = val & 10'h3ff;
        REG_ACTIVE_LINES:    act_lines = val & 9'h1ff;
        REG_ACTIVE_WIDTH:    act_width = val & 10'h3ff;
        REG_BLANK_LINES:     blank = val & 6'h3f;
        default: ;
      endcase
    endfunction

    function int unsigned clamp(longint v);
      if (v < 0) return 0;
      if (v > SMAX) return SMAX;
      return int'(v);
    endfunction

    function int unsigned pixel_level(bit [7:0] r, bit [7:0] g, bit [7:0] b, int k);
      longint y, dr, db, ci, cq, c, num;
      y  = 307 * longint'(r) + 604 * longint'(g) + 113 * longint'(b);
      dr = 1024 * longint'(r) - y;
      db = 1024 * longint'(b) - y;
      ci = (758 * dr - 276 * db + 512) >>> 10;
      cq = (492 * dr + 420 * db + 512) >>> 10;
      c  = (cq * rot_sin[k] + ci * rot_cos[k] + 8192) >>> 14;
      if (!odd) c = -c;
      num = longint'(black) * DEN + y * longint'(luma) + c * longint'(chroma) + DEN / 2;
      if (num < 0) return 0;
      return clamp(num / DEN);
    endfunction

    function int unsigned burst_level(int k);
      longint d;
      d = (longint'(amp) * base_sin[k] + 8192) >>> 14;
      if (odd) d = -d;
      return clamp(longint'(black) + d);
    endfunction

    // one accepted pixel item: work out its sample and advance the raster
    function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      int unsigned s, ln, lvl, total, v;
      int k;
      sample_item_t e;
      s = sample_pos; ln = line_pos; lvl = black;
      total = act_lines + VS_LINES + blank;
      k = (phase > 4) ? 0 : phase;
      e.taken = 0;
      if (ln >= act_lines && ln < act_lines + VS_LINES) begin
        v = ln - act_lines;
        if (v >= 3 && v <= 5) begin
          // broad pulses
          if (s < VS_LONG || (s >= VS_LONG + VS_SHORT && s < 2 * VS_LONG + VS_SHORT))
            lvl = 0;
        end else begin
          // equalizing pulses
          if (s < VS_SHORT || (s >= VS_SHORT + VS_LONG && s < 2 * VS_SHORT + VS_LONG))
            lvl = 0;
        end
      end else if (s >= SYNC_AT && s < PRE_AT) begin
        lvl = 0;
      end else if (s >= BURST_AT && s < POST_AT) begin
        lvl = burst_level(k);
      end else if (ln < act_lines && s >= PIC_AT && s - PIC_AT < act_width) begin
        lvl = pixel_level(r, g, b, k);
        e.taken = 1;
        pixels_seen++;
      end
      e.smp  = lvl[9:0];
      e.lend = (s >= LINE - 1);
      e.fend = e.lend && (total == 0 || ln >= total - 1);
      pending_q.push_back(e);
      phase = (k + 1) % 5;
      if (e.lend) begin
        sample_pos = 0;
        odd = !odd;
        line_pos = (ln + 1) & 10'h3ff;
        if (e.fend) begin
          line_pos = 0; odd = 0; phase = 0;
          fields_seen++;
        end
      end else begin
        sample_pos = s + 1;
      end
    endfunction

    function void check_sample(logic [9:0] smp, logic taken, logic lend, logic fend);
      sample_item_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: sample item with nothing expected: sample %0d", $time, smp);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (smp !== e.smp) begin
        $display("%0t: sample expected %0d actual %0d", $time, e.smp, smp);
        errors++;
      end
      if (taken !== e.taken) begin
        $display("%0t: pixel_taken expected %0d actual %0d", $time, e.taken, taken);
        errors++;
      end
      if (lend !== e.lend) begin
        $display("%0t: line_end expected %0d actual %0d", $time, e.lend, lend);
        errors++;
      end
      if (fend !== e.fend) begin
        $display("%0t: field_end expected %0d actual %0d", $time, e.fend, fend);
        errors++;
      end
    endfunction
  endclass

  logic                      clk, rst;
  logic                      cfg_valid, cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid, in_ready;
  logic [7:0]                red, green, blue;
  logic                      out_valid, out_ready;
  logic [9:0]                sample;
  logic                      pixel_taken, line_end, field_end;

  raster_board board;
  int send_idle_pct, recv_idle_pct;
  int samples_got, hold_left, quiet_cycles;
  bit hold_done;

  composite_video_encoder i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready), .sample(sample),
    .pixel_taken(pixel_taken), .line_end(line_end), .field_end(field_end)
  );

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 0;
      hold_left--;
    end else if (!hold_done && samples_got >= 300) begin
      hold_done = 1;
      hold_left = 300;
      out_ready = 0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // sample monitor, checked at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_sample(sample, pixel_taken, line_end, field_end);
      samples_got++;
    end
  end

  // watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog expired, %0d samples outstanding", $time,
               board.pending_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // register write; called and returns at a falling edge
  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val[CFG_DATA_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // offer one pixel item; valid stays high after accept for the next call
  task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    red = r; green = g; blue = b;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(r, g, b);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    bit [7:0] r, g, b;
    repeat (n) begin
      case ($urandom_range(9))
        0: begin r = 0; g = 0; b = 0; end
        1: begin r = 8'hff; g = 8'hff; b = 8'hff; end
        2: begin r = 8'hff; g = 0; b = 0; end
        3: begin r = 0; g = 0; b = 8'hff; end
        default: begin r = $urandom; g = $urandom; b = $urandom; end
      endcase
      send_pixel(r, g, b);
    end
    in_valid = 0;
  endtask

  // wait until every sample has come back, then let the pipeline drain
  task automatic drain();
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (CALC_CYCLES + 4) @(negedge clk);
  endtask

  initial begin
    rst = 1;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; red = 0; green = 0; blue = 0;
    out_ready = 0;
    samples_got = 0; hold_left = 0; hold_done = 0; quiet_cycles = 0;
    send_idle_pct = 30; recv_idle_pct = 69;
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings: directed color extremes, then random pixels
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_random(490);
    drain();

    // extreme registers: one picture line, no blank lines, full width so the
    // picture runs up to the last sample before the line end
    send_idle_pct = 69; recv_idle_pct = 30;
    write_reg(REG_BLANK_LEVEL, 0);
    write_reg(REG_BURST_AMPLITUDE, 511);
    write_reg(REG_LUMA_GAIN, 1023);
    write_reg(REG_CHROMA_GAIN, 1023);
    write_reg(REG_ACTIVE_LINES, 1);
    write_reg(REG_ACTIVE_WIDTH, 760);
    write_reg(REG_BLANK_LINES, 0);
    send_random(500);
    drain();

    // other extremes, zero width so no pixel is taken
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_BLANK_LEVEL, 1023);
    write_reg(REG_BURST_AMPLITUDE, 0);
    write_reg(REG_LUMA_GAIN, 0);
    write_reg(REG_CHROMA_GAIN, 0);
    write_reg(REG_ACTIVE_LINES, 480);
    write_reg(REG_ACTIVE_WIDTH, 0);
    write_reg(REG_BLANK_LINES, 63);
    send_random(300);
    drain();

    // random mid-range settings
    write_reg(REG_BLANK_LEVEL, $urandom_range(400, 100));
    write_reg(REG_BURST_AMPLITUDE, $urandom_range(511));
    write_reg(REG_LUMA_GAIN, $urandom_range(1023, 512));
    write_reg(REG_CHROMA_GAIN, $urandom_range(1023));
    write_reg(REG_ACTIVE_LINES, $urandom_range(3, 1));
    write_reg(REG_ACTIVE_WIDTH, $urandom_range(760, 1));
    write_reg(REG_BLANK_LINES, $urandom_range(63));
    send_random(350);
    drain();

    $display("covered %0d sample items, %0d picture samples, %0d field ends",
             samples_got, board.pixels_seen, board.fields_seen);
    $display("four register settings incl. extremes, three stall patterns, one long hold-off");
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
